FILE: rtl/core/cpi_pkg.sv
// Shared types and constants for the cyclic prefix inserter.
package cpi_pkg;

    // Register and payload widths fixed by the interface
    localparam int CFG_W   = 12;
    localparam int FIELD_W = 16;
    localparam int IDX_W   = 2;

    typedef logic [CFG_W-1:0]          t_cfg_word;
    typedef logic [IDX_W-1:0]          t_cfg_idx;
    typedef logic signed [FIELD_W-1:0] t_sample;

    // Register indexes
    localparam t_cfg_idx REG_BLOCK_LEN  = 2'd0;
    localparam t_cfg_idx REG_PREFIX_LEN = 2'd1;

    // Register reset values
    localparam t_cfg_word BLOCK_LEN_RST  = 12'd64;
    localparam t_cfg_word PREFIX_LEN_RST = 12'd16;

    // Command codes
    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_PULL = 1'b1;

endpackage

FILE: rtl/core/cyclic_prefix_inserter.sv
// Cyclic prefix inserter: ping-pong sample store with framed read-out.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+----------------------------------------------------
//  in      | input     | i_valid / o_stall  | i_cmd, i_sample_re, i_sample_im
//  out     | output    | o_valid / i_stall  | o_out_{valid,re,im}, o_last_of_frame, o_push_dropped
//  cfg     | input     | i_cfg_we           | i_cfg_index, i_cfg_data
//
// One word in and one result word out per cycle while nothing stalls.
// An accepted word passes through the store read stage, then sits in the output register.
// Synchronous active-low reset clears control state; the store is not cleared.
// A stalled output holds the output register and one more word in the read stage;
// input stall then follows output stall in the same cycle.
// The input also stalls during a register write and the cycle after it.
module cyclic_prefix_inserter #(
    parameter int MAX_BLOCK   = 2048,
    parameter int SAMPLE_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // input channel
    input  logic               i_valid,
    output logic               o_stall,
    input  logic               i_cmd,
    input  cpi_pkg::t_sample   i_sample_re,
    input  cpi_pkg::t_sample   i_sample_im,
    // output channel
    output logic               o_valid,
    input  logic               i_stall,
    output logic               o_out_valid,
    output cpi_pkg::t_sample   o_out_re,
    output cpi_pkg::t_sample   o_out_im,
    output logic               o_last_of_frame,
    output logic               o_push_dropped,
    // configuration port
    input  logic               i_cfg_we,
    input  cpi_pkg::t_cfg_idx  i_cfg_index,
    input  cpi_pkg::t_cfg_word i_cfg_data
);
    import cpi_pkg::*;

    localparam int AW    = $clog2(MAX_BLOCK);
    localparam int MW    = AW + 1;
    localparam int DEPTH = 2 ** MW;
    localparam int LW    = $clog2(MAX_BLOCK + 1);
    localparam int BW    = (LW > CFG_W) ? LW : CFG_W;
    localparam int TW    = BW + 1;
    localparam int DW    = 2 * SAMPLE_BITS;
    localparam logic [BW-1:0] MAX_B = BW'(MAX_BLOCK);

    // Configuration registers
    t_cfg_word r_block_len, r_prefix_len;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_len  <= BLOCK_LEN_RST;
            r_prefix_len <= PREFIX_LEN_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_BLOCK_LEN:  r_block_len  <= i_cfg_data;
                REG_PREFIX_LEN: r_prefix_len <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Effective block, prefix and frame lengths, registered off the config
    logic [BW-1:0] blk_ext, pfx_ext, eff_b, eff_p;
    logic [BW-1:0] r_eff_b, r_eff_p;
    logic [TW-1:0] r_total;

    always_comb begin
        blk_ext = BW'(r_block_len);
        pfx_ext = BW'(r_prefix_len);
        if (blk_ext == '0)
            eff_b = BW'(1);
        else if (blk_ext > MAX_B)
            eff_b = MAX_B;
        else
            eff_b = blk_ext;
        eff_p = (pfx_ext > eff_b) ? eff_b : pfx_ext;
    end

    always_ff @(posedge i_clk) begin
        r_eff_b <= eff_b;
        r_eff_p <= eff_p;
        r_total <= TW'(eff_b) + TW'(eff_p);
    end

    // Handshake and pipeline flow
    logic r_s1_valid, r_o_valid, r_cfg_hold;
    logic move_s1, accept, is_push, is_pull;

    assign move_s1 = r_s1_valid && (!r_o_valid || !i_stall);
    assign o_stall = (r_s1_valid && !move_s1) || i_cfg_we || r_cfg_hold;
    assign accept  = i_valid && !o_stall;
    assign is_push = (i_cmd == CMD_PUSH);
    assign is_pull = (i_cmd == CMD_PULL);

    // Hold the input off while the derived lengths catch up with a register write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_cfg_hold <= 1'b0;
        else
            r_cfg_hold <= i_cfg_we;
    end

    // Bank control state
    logic          r_fill_bank, r_drain_bank;
    logic [AW-1:0] r_fill_count;
    logic [1:0]    r_bank_ready;
    logic [TW-1:0] r_drain_index;

    logic          n_fill_bank, n_drain_bank;
    logic [AW-1:0] n_fill_count;
    logic [1:0]    n_bank_ready;
    logic [TW-1:0] n_drain_index;

    logic          fill_full, fill_done, drain_rdy, drain_last;
    logic          wr_en, rd_en;
    logic [TW-1:0] dix, src;
    logic [MW-1:0] wr_addr, rd_addr;

    always_comb begin
        fill_full  = r_bank_ready[r_fill_bank];
        fill_done  = (TW'(r_fill_count) + TW'(1)) >= TW'(r_eff_b);
        drain_rdy  = r_bank_ready[r_drain_bank];
        // clamp an index left beyond a shortened frame
        dix        = (r_drain_index >= r_total) ? (r_total - TW'(1)) : r_drain_index;
        drain_last = (dix == (r_total - TW'(1)));
        // prefix reads the block tail, then the whole block follows
        if (dix < TW'(r_eff_p))
            src = TW'(r_eff_b) - TW'(r_eff_p) + dix;
        else
            src = dix - TW'(r_eff_p);

        wr_en   = accept && is_push && !fill_full;
        rd_en   = accept && is_pull && drain_rdy;
        wr_addr = {r_fill_bank, r_fill_count};
        rd_addr = {r_drain_bank, src[AW-1:0]};

        n_fill_bank   = r_fill_bank;
        n_fill_count  = r_fill_count;
        n_bank_ready  = r_bank_ready;
        n_drain_bank  = r_drain_bank;
        n_drain_index = r_drain_index;

        if (wr_en) begin
            if (fill_done) begin
                n_bank_ready[r_fill_bank] = 1'b1;
                n_fill_bank  = ~r_fill_bank;
                n_fill_count = '0;
            end else begin
                n_fill_count = r_fill_count + AW'(1);
            end
        end

        if (rd_en) begin
            if (drain_last) begin
                n_bank_ready[r_drain_bank] = 1'b0;
                n_drain_bank  = ~r_drain_bank;
                n_drain_index = '0;
            end else begin
                n_drain_index = dix + TW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill_bank   <= 1'b0;
            r_fill_count  <= '0;
            r_bank_ready  <= 2'b00;
            r_drain_bank  <= 1'b0;
            r_drain_index <= '0;
        end else begin
            r_fill_bank   <= n_fill_bank;
            r_fill_count  <= n_fill_count;
            r_bank_ready  <= n_bank_ready;
            r_drain_bank  <= n_drain_bank;
            r_drain_index <= n_drain_index;
        end
    end

    // Sample store: two banks of MAX_BLOCK (rounded up to a power of two) complex entries, {im, re}
    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] r_rd_data;
    logic [DW-1:0] wr_data;

    assign wr_data = {SAMPLE_BITS'($unsigned(i_sample_im)),
                      SAMPLE_BITS'($unsigned(i_sample_re))};

    always_ff @(posedge i_clk) begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
    end

    always_ff @(posedge i_clk) begin
        if (rd_en)
            r_rd_data <= mem[rd_addr];
    end

    // Read stage: result flags travel beside the store read
    logic r_s1_hit, r_s1_last, r_s1_drop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_s1_valid <= 1'b0;
        else if (accept)
            r_s1_valid <= 1'b1;
        else if (move_s1)
            r_s1_valid <= 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_hit  <= rd_en;
            r_s1_last <= rd_en && drain_last;
            r_s1_drop <= is_push && fill_full;
        end
    end

    // Output register
    t_sample r_o_re, r_o_im;
    logic    r_o_hit, r_o_last, r_o_drop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_o_valid <= 1'b0;
        else if (move_s1)
            r_o_valid <= 1'b1;
        else if (!i_stall)
            r_o_valid <= 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (move_s1) begin
            r_o_hit  <= r_s1_hit;
            r_o_last <= r_s1_last;
            r_o_drop <= r_s1_drop;
            r_o_re   <= r_s1_hit ? FIELD_W'(r_rd_data[SAMPLE_BITS-1:0]) : '0;
            r_o_im   <= r_s1_hit ? FIELD_W'(r_rd_data[DW-1:SAMPLE_BITS]) : '0;
        end
    end

    assign o_valid         = r_o_valid;
    assign o_out_valid     = r_o_hit;
    assign o_out_re        = r_o_re;
    assign o_out_im        = r_o_im;
    assign o_last_of_frame = r_o_last;
    assign o_push_dropped  = r_o_drop;

endmodule

FILE: dv/testbench.sv
// Self-checking testbench for the cyclic prefix inserter: randomized words, framed read-out check.
module testbench;
    import cpi_pkg::*;

    localparam int MAX_BLOCK = 2048;
    // Spare register indexes with no register behind them
    localparam t_cfg_idx REG_SPARE_A = 2'd2;
    localparam t_cfg_idx REG_SPARE_B = 2'd3;

    typedef struct {
        logic    cmd;
        t_sample re;
        t_sample im;
        bit      hold;   // wait until the block has drained before sending
    } t_cp_word;

    typedef struct packed {
        logic    vld;
        t_sample re;
        t_sample im;
        logic    last;
        logic    drop;
    } t_cp_result;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_valid = 1'b0;
    logic      o_stall;
    logic      i_cmd = CMD_PUSH;
    t_sample   i_sample_re = '0;
    t_sample   i_sample_im = '0;
    logic      o_valid;
    logic      i_stall = 1'b0;
    logic      o_out_valid;
    t_sample   o_out_re;
    t_sample   o_out_im;
    logic      o_last_of_frame;
    logic      o_push_dropped;
    logic      i_cfg_we = 1'b0;
    t_cfg_idx  i_cfg_index = REG_BLOCK_LEN;
    t_cfg_word i_cfg_data = '0;

    cyclic_prefix_inserter #(
        .MAX_BLOCK   (MAX_BLOCK),
        .SAMPLE_BITS (16)
    ) u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_cmd           (i_cmd),
        .i_sample_re     (i_sample_re),
        .i_sample_im     (i_sample_im),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_out_valid     (o_out_valid),
        .o_out_re        (o_out_re),
        .o_out_im        (o_out_im),
        .o_last_of_frame (o_last_of_frame),
        .o_push_dropped  (o_push_dropped),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Shadow copy of the block state and registers
    t_cfg_word   blk_reg = BLOCK_LEN_RST;
    t_cfg_word   pre_reg = PREFIX_LEN_RST;
    t_sample     store_re [2*MAX_BLOCK];
    t_sample     store_im [2*MAX_BLOCK];
    bit          written  [2*MAX_BLOCK];
    bit          fill_bank = 1'b0;
    int unsigned fill_cnt = 0;
    bit [1:0]    bank_ready = 2'b00;
    bit          drain_bank = 1'b0;
    int unsigned drain_idx = 0;

    t_cp_word    word_q[$];       // words waiting to be sent
    t_cp_result  out_words_q[$];  // result words the block still owes
    t_cp_word    on_bus;
    int          send_idle = 18;
    int          recv_idle = 79;
    int          n_miss = 0;
    int          n_words = 0;
    int          n_frames = 0;
    int          n_samples = 0;
    int          n_drops = 0;
    int          n_dry = 0;
    int          n_settings = 0;

    // Effective block length for a register value
    function automatic int unsigned span(t_cfg_word v);
        if (v == 0) return 1;
        if (v > MAX_BLOCK) return MAX_BLOCK;
        return v;
    endfunction

    function automatic int unsigned lead(int unsigned b);
        return (pre_reg > b) ? b : pre_reg;
    endfunction

    function automatic int unsigned slot(bit bank, int unsigned i);
        return bank * MAX_BLOCK + i;
    endfunction

    // Next result word for one accepted input word; updates the shadow state
    function automatic t_cp_result insert_prefix(t_cp_word w);
        int unsigned b, p, total, idx, src;
        t_cp_result r;
        b = span(blk_reg);
        p = lead(b);
        total = p + b;
        r = '0;
        if (w.cmd == CMD_PUSH) begin
            if (bank_ready[fill_bank]) begin
                r.drop = 1'b1;
                n_drops++;
                return r;
            end
            idx = (fill_cnt < MAX_BLOCK) ? fill_cnt : MAX_BLOCK - 1;
            store_re[slot(fill_bank, idx)] = w.re;
            store_im[slot(fill_bank, idx)] = w.im;
            written[slot(fill_bank, idx)] = 1'b1;
            if (idx + 1 >= b) begin
                bank_ready[fill_bank] = 1'b1;
                fill_bank = ~fill_bank;
                fill_cnt = 0;
            end else begin
                fill_cnt = idx + 1;
            end
        end else if (!bank_ready[drain_bank]) begin
            n_dry++;
        end else begin
            // frame is the tail of the block, then the whole block
            if (drain_idx >= total) drain_idx = total - 1;
            src = (drain_idx < p) ? b - p + drain_idx : drain_idx - p;
            r.vld = 1'b1;
            r.re = store_re[slot(drain_bank, src)];
            r.im = store_im[slot(drain_bank, src)];
            n_samples++;
            if (drain_idx == total - 1) begin
                r.last = 1'b1;
                n_frames++;
                bank_ready[drain_bank] = 1'b0;
                drain_bank = ~drain_bank;
                drain_idx = 0;
            end else begin
                drain_idx++;
            end
        end
        return r;
    endfunction

    // True when every ready bank holds written samples up to the new length
    function automatic bit reads_covered(t_cfg_word blk);
        int unsigned nb;
        nb = span(blk);
        for (int k = 0; k < 2; k++) begin
            if (bank_ready[k]) begin
                for (int unsigned i = 0; i < nb; i++) begin
                    if (!written[slot(k, i)]) return 1'b0;
                end
            end
        end
        return 1'b1;
    endfunction

    // Driver: one word per handshake, payload held while stalled
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                out_words_q.push_back(insert_prefix(on_bus));
                n_words++;
            end
            if (!i_valid || !o_stall) begin
                if (word_q.size() == 0 || $urandom_range(99) < send_idle
                    || (word_q[0].hold && out_words_q.size() != 0)) begin
                    i_valid <= 1'b0;
                end else begin
                    on_bus = word_q.pop_front();
                    i_valid <= 1'b1;
                    i_cmd <= on_bus.cmd;
                    i_sample_re <= on_bus.re;
                    i_sample_im <= on_bus.im;
                end
            end
        end
    end

    // Monitor: compare each output word with the oldest owed word
    always @(posedge i_clk) begin
        t_cp_result got, want;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                got.vld = o_out_valid;
                got.re = o_out_re;
                got.im = o_out_im;
                got.last = o_last_of_frame;
                got.drop = o_push_dropped;
                if (out_words_q.size() == 0) begin
                    if (n_miss < 10) $display("%0t: output word with none owed", $time);
                    n_miss++;
                end else begin
                    want = out_words_q.pop_front();
                    if (got !== want) begin
                        if (n_miss < 10)
                            $display({"%0t: mismatch want vld=%0b re=%0d im=%0d last=%0b ",
                                      "drop=%0b / got vld=%0b re=%0d im=%0d last=%0b drop=%0b"},
                                     $time, want.vld, want.re, want.im, want.last, want.drop,
                                     got.vld, got.re, got.im, got.last, got.drop);
                        n_miss++;
                    end
                end
            end
            i_stall <= ($urandom_range(99) < recv_idle);
        end
    end

    task automatic queue_word(logic cmd, t_sample re, t_sample im, bit hold);
        t_cp_word w;
        w.cmd = cmd;
        w.re = re;
        w.im = im;
        w.hold = hold;
        word_q.push_back(w);
    endtask

    task automatic queue_words(logic cmd, int unsigned k, bit hold_first);
        for (int unsigned i = 0; i < k; i++)
            queue_word(cmd, t_sample'($urandom), t_sample'($urandom), hold_first && i == 0);
    endtask

    // Mix of whole blocks, whole frames and loose words
    task automatic queue_bursts(int unsigned n);
        int unsigned made, b, p, k, r, bursts;
        made = 0;
        bursts = 0;
        b = span(blk_reg);
        p = lead(b);
        while (made < n) begin
            r = $urandom_range(99);
            if (r < 40) begin
                k = b;
                queue_words(CMD_PUSH, k, bursts == 1 || $urandom_range(99) < 3);
            end else if (r < 80) begin
                k = b + p;
                queue_words(CMD_PULL, k, bursts == 1 || $urandom_range(99) < 3);
            end else begin
                k = $urandom_range(6, 1);
                for (int unsigned i = 0; i < k; i++)
                    queue_words($urandom_range(1) ? CMD_PULL : CMD_PUSH, 1, 1'b0);
            end
            made += k;
            bursts++;
        end
    endtask

    task automatic settle(int n);
        repeat (n) @(negedge i_clk);
    endtask

    task automatic run_until_idle();
        do @(negedge i_clk);
        while (word_q.size() != 0 || i_valid || out_words_q.size() != 0);
    endtask

    task automatic write_reg(t_cfg_idx idx, t_cfg_word val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        case (idx)
            REG_BLOCK_LEN:  blk_reg = val;
            REG_PREFIX_LEN: pre_reg = val;
            default: ;
        endcase
    endtask

    // Registers change only with the block idle; ready banks are drained first
    // if a longer block would reach samples never stored
    task automatic reconfigure(t_cfg_word blk, t_cfg_word pre, bit poke_spare);
        int unsigned b, total, n;
        if (!reads_covered(blk)) begin
            b = span(blk_reg);
            total = lead(b) + b;
            n = 0;
            if (bank_ready[drain_bank]) n += (drain_idx < total) ? total - drain_idx : 1;
            if (bank_ready[~drain_bank]) n += total;
            queue_words(CMD_PULL, n, 1'b0);
            run_until_idle();
        end
        settle(3);
        write_reg(REG_BLOCK_LEN, blk);
        write_reg(REG_PREFIX_LEN, pre);
        if (poke_spare) begin
            write_reg(REG_SPARE_A, t_cfg_word'($urandom));
            write_reg(REG_SPARE_B, t_cfg_word'($urandom));
        end
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        n_settings++;
        settle(3);
    endtask

    // Stimulus sequence
    initial begin
        t_cfg_word blk, pre;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty pull, extreme samples, both banks full, drop,
        // then shrink the block mid-drain and mid-fill
        reconfigure(12'd4, 12'd2, 1'b0);
        queue_words(CMD_PULL, 1, 1'b0);
        queue_word(CMD_PUSH, 16'sh8000, 16'sh7FFF, 1'b0);
        queue_word(CMD_PUSH, 16'sh7FFF, 16'sh8000, 1'b0);
        queue_word(CMD_PUSH, 16'sh0000, 16'sh0000, 1'b0);
        queue_word(CMD_PUSH, 16'shFFFF, 16'sh0001, 1'b0);
        queue_words(CMD_PUSH, 5, 1'b0);
        queue_words(CMD_PULL, 8, 1'b0);
        queue_words(CMD_PUSH, 3, 1'b0);
        run_until_idle();
        reconfigure(12'd2, 12'd0, 1'b1);
        queue_words(CMD_PULL, 1, 1'b0);
        queue_words(CMD_PUSH, 1, 1'b0);
        queue_words(CMD_PULL, 2, 1'b0);
        run_until_idle();

        // Random phases over several settings, extremes among them
        for (int ph = 0; ph < 9; ph++) begin
            case (ph / 3)
                0: begin send_idle = 18; recv_idle = 79; end
                1: begin send_idle = 79; recv_idle = 18; end
                default: begin send_idle = 0; recv_idle = 0; end
            endcase
            case (ph)
                0: begin blk = 12'd4;    pre = 12'd2;    end
                1: begin blk = 12'd1;    pre = 12'd0;    end
                2: begin blk = 12'd0;    pre = 12'd5;    end
                3: begin blk = 12'd8;    pre = 12'd8;    end
                4: begin blk = 12'd3;    pre = 12'hFFF;  end
                6: begin blk = 12'hFFF;  pre = 12'hFFF;  end
                default: begin
                    blk = t_cfg_word'($urandom_range(12, 1));
                    pre = t_cfg_word'($urandom_range(15, 0));
                end
            endcase
            reconfigure(blk, pre, ph == 5);
            if (ph == 6) begin
                // part of a clamped full-size block; pulls find nothing ready,
                // and the next shorter block completes on its first push
                queue_words(CMD_PUSH, 20, 1'b0);
                queue_words(CMD_PULL, 4, 1'b0);
            end else begin
                queue_bursts(100);
            end
            run_until_idle();
        end

        settle(20);
        $display("Sent %0d words over %0d register settings: %0d frames, %0d samples out,",
                 n_words, n_settings, n_frames, n_samples);
        $display("%0d dropped pushes, %0d pulls with nothing ready, %0d mismatches.",
                 n_drops, n_dry, n_miss);
        if (n_miss == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #10_000_000;
        $display("Timeout with %0d result words still owed", out_words_q.size());
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

FILE: files.f
rtl/core/cpi_pkg.sv
rtl/core/cyclic_prefix_inserter.sv
dv/testbench.sv
